>>> src/adsreg_pkg.sv
// ----------------------------------------------------------------------------
// adsreg_pkg: shared types and constants of the ADSR envelope gain unit
// Word layouts of both channels, register map, voice phases, sequencer
// states and the fixed widths of the shared multiplier.
// ----------------------------------------------------------------------------
package adsreg_pkg;

  // Input opcodes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [1:0] OP_NOTE_OFF = 2'd2;

  // Register map (index = byte address / 4)
  localparam int          CFG_ADDR_W    = 5;
  localparam logic [2:0]  REG_ATTACK    = 3'd0;
  localparam logic [2:0]  REG_DECAY     = 3'd1;
  localparam logic [2:0]  REG_SUSTAIN   = 3'd2;
  localparam logic [2:0]  REG_RELEASE   = 3'd3;
  localparam logic [2:0]  REG_ECHO_LVL  = 3'd4;
  localparam logic [2:0]  REG_ECHO_LEN  = 3'd5;
  localparam logic [2:0]  REG_LEFT_VOL  = 3'd6;
  localparam logic [2:0]  REG_RIGHT_VOL = 3'd7;

  // Envelope and gain arithmetic
  localparam logic [7:0] ENV_MAX     = 8'hFF;
  localparam int         SCALE_SHIFT = 8;
  localparam int         GAIN_LSB    = 13;

  // Shared multiplier: 16 x 8 unsigned
  localparam int MUL_A_W = 16;
  localparam int MUL_B_W = 8;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_START   = 3'd1,
    PH_ATTACK  = 3'd2,
    PH_DECAY   = 3'd3,
    PH_SUSTAIN = 3'd4,
    PH_RELEASE = 3'd5,
    PH_ECHO    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PROD,
    S_LEFT,
    S_RIGHT,
    S_GAIN,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] master_level;
  } in_word_t;

  typedef struct packed {
    logic [7:0] env_level;
    logic [7:0] left_gain;
    logic [7:0] right_gain;
    logic [2:0] voice_phase;
  } out_word_t;

  typedef struct packed {
    logic [7:0] attack_rate;
    logic [7:0] decay_rate;
    logic [7:0] sustain_level;
    logic [7:0] release_rate;
    logic [7:0] echo_level;
    logic [7:0] echo_length;
    logic [7:0] left_volume;
    logic [7:0] right_volume;
  } cfg_t;

endpackage

>>> src/adsreg_cfg.sv
// ----------------------------------------------------------------------------
// adsreg_cfg: configuration register file
// Eight 8-bit registers written and read over an APB-style port.
// ----------------------------------------------------------------------------
module adsreg_cfg
  import adsreg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic [7:0] rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg     = cfg_r;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ATTACK:    cfg_nxt.attack_rate   = pwdata[7:0];
        REG_DECAY:     cfg_nxt.decay_rate    = pwdata[7:0];
        REG_SUSTAIN:   cfg_nxt.sustain_level = pwdata[7:0];
        REG_RELEASE:   cfg_nxt.release_rate  = pwdata[7:0];
        REG_ECHO_LVL:  cfg_nxt.echo_level    = pwdata[7:0];
        REG_ECHO_LEN:  cfg_nxt.echo_length   = pwdata[7:0];
        REG_LEFT_VOL:  cfg_nxt.left_volume   = pwdata[7:0];
        REG_RIGHT_VOL: cfg_nxt.right_volume  = pwdata[7:0];
      endcase
    end
  end

  // Select the read word
  always_comb begin
    unique case (reg_idx)
      REG_ATTACK:    rd_val = cfg_r.attack_rate;
      REG_DECAY:     rd_val = cfg_r.decay_rate;
      REG_SUSTAIN:   rd_val = cfg_r.sustain_level;
      REG_RELEASE:   rd_val = cfg_r.release_rate;
      REG_ECHO_LVL:  rd_val = cfg_r.echo_level;
      REG_ECHO_LEN:  rd_val = cfg_r.echo_length;
      REG_LEFT_VOL:  rd_val = cfg_r.left_volume;
      REG_RIGHT_VOL: rd_val = cfg_r.right_volume;
    endcase
  end

  assign prdata = {24'd0, rd_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> src/adsreg_mul.sv
// ----------------------------------------------------------------------------
// adsreg_mul: shared unsigned multiplier
// One 16 x 8 product per cycle, result registered.
// ----------------------------------------------------------------------------
module adsreg_mul
  import adsreg_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] op_a,
  input  logic [MUL_B_W-1:0] op_b,
  output logic [MUL_P_W-1:0] prod
);

  logic [MUL_P_W-1:0] prod_r;
  logic [MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = MUL_P_W'(op_a) * MUL_P_W'(op_b);
  assign prod     = prod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

>>> src/adsr_echo_envelope_gain_unit.sv
// ----------------------------------------------------------------------------
// adsr_echo_envelope_gain_unit: per-voice ADSR envelope with echo tail
// Sequenced envelope step and master-scaled stereo gains.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per item (tick, note-on, note-off), valid/stall handshake.
//   out_* : one word per item with envelope, left/right gain and voice phase.
//   APB   : eight 8-bit registers at byte addresses 0x00..0x1C; write only
//           while the block is idle.
// Sequencing (output register free):
//   A tick on a sounding voice walks a small sequencer around one shared
//   16x8 multiplier: envelope scale, master product, left gain, right gain.
//   Its result is loaded into the output register from the emit step, and the
//   next word is accepted in the cycle the result is offered. A tick that
//   switches the voice off skips the gain steps and goes straight to emit.
//   Note-on, note-off, an unused opcode and a tick on a silent voice go from
//   acceptance straight to emit. in_stall is high while an item is in work.
// Stall and reset:
//   The result sits in an output register; the block accepts the next word
//   while it waits, and holds only when a new result finds it still stalled.
//   Reset clears the control registers, the envelope, gains and phase (voice off).
// ----------------------------------------------------------------------------
module adsr_echo_envelope_gain_unit
  import adsreg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t               cfg;
  seq_state_t         state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [7:0]         env_r, env_nxt;
  logic               stop_r, stop_nxt;
  logic [7:0]         echo_cnt_r, echo_cnt_nxt;
  logic [7:0]         lgain_r, lgain_nxt;
  logic [7:0]         rgain_r, rgain_nxt;
  logic [MUL_A_W-1:0] prod_r, prod_nxt;
  logic [7:0]         mst_r;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r;
  logic               accept;
  logic               load;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  adsreg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  adsreg_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer: next state, envelope update and multiplier operands
  always_comb begin
    logic [8:0] sum9;
    logic [7:0] scaled;
    logic [8:0] mst_inc;
    logic       go_off;

    state_nxt    = state_r;
    phase_nxt    = phase_r;
    env_nxt      = env_r;
    stop_nxt     = stop_r;
    echo_cnt_nxt = echo_cnt_r;
    lgain_nxt    = lgain_r;
    rgain_nxt    = rgain_r;
    prod_nxt     = prod_r;
    load         = 1'b0;
    go_off       = 1'b0;

    sum9    = {1'b0, (phase_r == PH_START) ? 8'd0 : env_r} + {1'b0, cfg.attack_rate};
    scaled  = mul_p[SCALE_SHIFT +: 8];
    mst_inc = {1'b0, mst_r} + 9'd1;

    // Default operands start the decay/release scale as a word is accepted
    mul_a = MUL_A_W'(env_r);
    mul_b = (phase_r == PH_DECAY) ? cfg.decay_rate : cfg.release_rate;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EMIT;
          unique case (in_data.opcode)
            OP_TICK: begin
              if (phase_r != PH_OFF) begin
                state_nxt = S_EVAL;
              end
            end
            OP_NOTE_ON: begin
              env_nxt      = '0;
              lgain_nxt    = '0;
              rgain_nxt    = '0;
              echo_cnt_nxt = cfg.echo_length;
              stop_nxt     = 1'b0;
              phase_nxt    = PH_START;
            end
            OP_NOTE_OFF: begin
              if (phase_r == PH_START) begin
                stop_nxt = 1'b1;
              end else if (phase_r == PH_ATTACK || phase_r == PH_DECAY ||
                           phase_r == PH_SUSTAIN) begin
                stop_nxt  = 1'b1;
                phase_nxt = PH_RELEASE;
              end
            end
            default: ;
          endcase
        end
      end

      // Advance the envelope one step
      S_EVAL: begin
        unique case (phase_r)
          PH_START, PH_ATTACK: begin
            if (phase_r == PH_START && stop_r) begin
              go_off = 1'b1;
            end else if (sum9 >= {1'b0, ENV_MAX}) begin
              env_nxt   = ENV_MAX;
              phase_nxt = PH_DECAY;
            end else begin
              env_nxt   = sum9[7:0];
              phase_nxt = PH_ATTACK;
            end
          end
          PH_ECHO: begin
            echo_cnt_nxt = echo_cnt_r - 8'd1;
            if (echo_cnt_r <= 8'd1) begin
              go_off = 1'b1;
            end
          end
          PH_RELEASE: begin
            if (scaled <= cfg.echo_level) begin
              if (cfg.echo_level == 8'd0) begin
                go_off = 1'b1;
              end else begin
                env_nxt   = cfg.echo_level;
                phase_nxt = PH_ECHO;
              end
            end else begin
              env_nxt = scaled;
            end
          end
          PH_DECAY: begin
            if (scaled <= cfg.sustain_level) begin
              if (cfg.sustain_level != 8'd0) begin
                env_nxt   = cfg.sustain_level;
                phase_nxt = PH_SUSTAIN;
              end else if (cfg.echo_level == 8'd0) begin
                go_off = 1'b1;
              end else begin
                env_nxt   = cfg.echo_level;
                phase_nxt = PH_ECHO;
              end
            end else begin
              env_nxt = scaled;
            end
          end
          default: ;
        endcase

        // Switch-off keeps envelope and gains
        if (go_off) begin
          env_nxt   = env_r;
          phase_nxt = PH_OFF;
          stop_nxt  = 1'b0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_PROD;
        end
      end

      // (master + 1) * envelope
      S_PROD: begin
        mul_a     = MUL_A_W'(mst_inc);
        mul_b     = env_r;
        state_nxt = S_LEFT;
      end

      // Hold the master product, scale by left volume
      S_LEFT: begin
        prod_nxt  = mul_p[MUL_A_W-1:0];
        mul_a     = mul_p[MUL_A_W-1:0];
        mul_b     = cfg.left_volume;
        state_nxt = S_RIGHT;
      end

      // Take left gain, scale by right volume
      S_RIGHT: begin
        lgain_nxt = mul_p[GAIN_LSB +: 8];
        mul_a     = prod_r;
        mul_b     = cfg.right_volume;
        state_nxt = S_GAIN;
      end

      S_GAIN: begin
        rgain_nxt = mul_p[GAIN_LSB +: 8];
        state_nxt = S_EMIT;
      end

      // Hand the word to the output register once it is free
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = load | (out_valid_r & out_stall);

  // Control and voice state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_OFF;
      env_r       <= '0;
      stop_r      <= 1'b0;
      echo_cnt_r  <= '0;
      lgain_r     <= '0;
      rgain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      env_r       <= env_nxt;
      stop_r      <= stop_nxt;
      echo_cnt_r  <= echo_cnt_nxt;
      lgain_r     <= lgain_nxt;
      rgain_r     <= rgain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (accept) begin
      mst_r <= in_data.master_level;
    end
    if (load) begin
      out_data_r.env_level   <= env_r;
      out_data_r.left_gain   <= lgain_r;
      out_data_r.right_gain  <= rgain_r;
      out_data_r.voice_phase <= phase_r;
    end
  end

  // A silent voice never carries a pending stop
  a_off_no_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_OFF) |-> !stop_r)
    else $error("stop pending while voice is off");

  // An accepted word always blocks the next one in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input not held off after acceptance");

  // A new result appears only from the emit step
  a_rose_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside emit step");

  // Attack is entered only from a pending start or itself
  a_attack_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_nxt == PH_ATTACK && phase_r != PH_ATTACK) |-> (phase_r == PH_START))
    else $error("attack entered from wrong phase");

endmodule
